FILE: design/ppd_pkg.sv
// Package for the port poke detection block: port count, request and status
// codes, and the structs passed between the input stage, the core and the result stage.
// No dependencies.
package ppd_pkg;

    // Number of ports on this node and the width of a port index that can also say "none".
    localparam int NUM_PORTS = 4;
    localparam int CUR_W     = $clog2(NUM_PORTS + 1);
    localparam logic [CUR_W-1:0] PORT_NONE = CUR_W'(NUM_PORTS);

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_INIT   = 2'd0,
        REQ_LINE   = 2'd1,
        REQ_POKE   = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req_type;

    // Verdict codes.
    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    // One input transaction.
    typedef struct packed {
        logic [1:0]           req_type;
        logic [1:0]           port;
        logic [NUM_PORTS-1:0] reply_lines;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic [1:0]           status;
        logic [CUR_W-1:0]     active_port;
        logic                 keep_line;
        logic                 awaiting_release;
        logic [NUM_PORTS-1:0] pulsed_ports;
        logic [NUM_PORTS-1:0] push_mask;
        logic [NUM_PORTS-1:0] reverse_mask;
        logic                 lines_released;
    } t_result;

endpackage

FILE: design/port_poke_detection_fsm_top.sv
// Top level of the port poke detection block: input register, detection core and
// result register. Depends on ppd_pkg, ppd_in_stage, ppd_core and ppd_out_stage.
//
// Port poke detection for daisy-chain topology discovery. Each request transaction
// (init, line event on a port, or poke-next with the sampled reply lines) yields exactly
// one result transaction. A request is registered on acceptance, evaluated in one pass of
// logic against the detection state, and its result is registered. The result is valid at
// the output once its request has left the input register and its result is loaded into
// the result register. One request per cycle is sustained as long as results are taken;
// the result register decides the rate when the output stalls. The is_first_node register
// is written through the configuration channel, which is always ready and must only be
// used while no transaction is in flight.
module port_poke_detection_fsm_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Request channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [1:0] i_port,
    input  logic [3:0] i_reply_lines,
    // Result channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [2:0] o_active_port,
    output logic       o_keep_line,
    output logic       o_awaiting_release,
    output logic [3:0] o_pulsed_ports,
    output logic [3:0] o_push_mask,
    output logic [3:0] o_reverse_mask,
    output logic       o_lines_released,
    // Configuration channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    ppd_pkg::t_req    w_in_req;
    ppd_pkg::t_req    w_held_req;
    ppd_pkg::t_result w_step_result;
    ppd_pkg::t_result w_out_result;
    logic             w_held;
    logic             w_can_load;
    logic             w_step;

    // Request payload.
    assign w_in_req.req_type    = i_req_type;
    assign w_in_req.port        = i_port;
    assign w_in_req.reply_lines = i_reply_lines;

    // A request leaves the input register when the result register can take its result.
    assign w_step      = w_held && w_can_load;
    assign o_cfg_ready = 1'b1;

    ppd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (w_in_req),
        .i_take  (w_step),
        .o_full  (w_held),
        .o_req   (w_held_req)
    );

    ppd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_step),
        .i_req      (w_held_req),
        .o_result   (w_step_result)
    );

    ppd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_req (w_held),
        .o_can_load (w_can_load),
        .i_result   (w_step_result),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (w_out_result)
    );

    // Result payload.
    assign o_status           = w_out_result.status;
    assign o_active_port      = w_out_result.active_port;
    assign o_keep_line        = w_out_result.keep_line;
    assign o_awaiting_release = w_out_result.awaiting_release;
    assign o_pulsed_ports     = w_out_result.pulsed_ports;
    assign o_push_mask        = w_out_result.push_mask;
    assign o_reverse_mask     = w_out_result.reverse_mask;
    assign o_lines_released   = w_out_result.lines_released;

`ifndef SYNTH
    // A successful poke holds the line and waits for a release.
    a_ok_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ppd_pkg::ST_OK) |-> (o_keep_line && o_awaiting_release))
        else $error("success result without held line");

    // The reversed port is a single port that was pulsed in the same step.
    a_ok_reverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ppd_pkg::ST_OK)
        |-> ($onehot(o_reverse_mask) && ((o_reverse_mask & ~o_pulsed_ports) == 4'd0)))
        else $error("reverse mask not a pulsed single port");

    // A full reset leaves no active port and no held line.
    a_released_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_lines_released)
        |-> (o_active_port == ppd_pkg::PORT_NONE && !o_keep_line && !o_awaiting_release))
        else $error("release result with active state");

    // A pushed line names a single port, which becomes active, with no verdict.
    a_push_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_push_mask != 4'd0)
        |-> ($onehot(o_push_mask) && o_status == ppd_pkg::ST_NONE
             && o_active_port != ppd_pkg::PORT_NONE))
        else $error("bad push mask");
`endif

endmodule

FILE: design/ppd_in_stage.sv
// Input register of the port poke detection block: captures one request transaction
// and holds it until the core moves it on. Depends on ppd_pkg.
module ppd_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ppd_pkg::t_req i_req,
    input  logic          i_take,
    output logic          o_full,
    output ppd_pkg::t_req o_req
);

    logic          r_full;
    logic          n_full;
    ppd_pkg::t_req r_req;
    logic          w_accept;

    // The register is free when empty or when its content leaves this cycle.
    assign o_stall  = r_full && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_full = r_full;
        if (w_accept) begin
            n_full = 1'b1;
        end else if (i_take) begin
            n_full = 1'b0;
        end
    end

    // Control flag with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    assign o_full = r_full;
    assign o_req  = r_req;

endmodule

FILE: design/ppd_core.sv
// Detection state and the single-pass step logic of the port poke detection block.
// Depends on ppd_pkg.
module ppd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    input  logic             i_step,
    input  ppd_pkg::t_req    i_req,
    output ppd_pkg::t_result o_result
);

    localparam int NP = ppd_pkg::NUM_PORTS;

    logic                     r_is_first;
    logic                     r_expect_release;
    logic [ppd_pkg::CUR_W-1:0] r_current_port;
    logic                     r_hold_line;
    logic [NP-1:0]            r_done;

    logic                     n_expect_release;
    logic [ppd_pkg::CUR_W-1:0] n_current_port;
    logic                     n_hold_line;
    logic [NP-1:0]            n_done;

    logic [NP-1:0]            w_undone;
    logic [NP-1:0]            w_hit;
    logic [NP-1:0]            w_first;
    logic [NP-1:0]            w_upto;
    logic [ppd_pkg::CUR_W-1:0] w_first_idx;
    logic                     w_scan;
    logic [1:0]               w_status;
    logic [NP-1:0]            w_pulsed;
    logic [NP-1:0]            w_push;
    logic [NP-1:0]            w_reverse;
    logic                     w_released;

    // Scan helpers: undone ports with a reply, the lowest of them, and every
    // undone port at or below it.
    assign w_undone = ~r_done;
    assign w_hit    = w_undone & i_req.reply_lines;
    assign w_first  = w_hit & (~w_hit + NP'(1));
    assign w_upto   = w_undone & (w_first | (w_first - NP'(1)));
    assign w_scan   = (r_current_port != ppd_pkg::PORT_NONE) || r_is_first;

    // Index of the lowest replying port.
    always_comb begin
        w_first_idx = '0;
        for (int p = NP - 1; p >= 0; p--) begin
            if (w_hit[p]) begin
                w_first_idx = ppd_pkg::CUR_W'(p);
            end
        end
    end

    // Next state and result fields for one request.
    always_comb begin
        n_expect_release = r_expect_release;
        n_current_port   = r_current_port;
        n_hold_line      = r_hold_line;
        n_done           = r_done;
        w_status         = ppd_pkg::ST_NONE;
        w_pulsed         = '0;
        w_push           = '0;
        w_reverse        = '0;
        w_released       = 1'b0;
        case (ppd_pkg::t_req_type'(i_req.req_type))
            ppd_pkg::REQ_INIT: begin
                n_expect_release = 1'b0;
                n_current_port   = ppd_pkg::PORT_NONE;
                n_hold_line      = 1'b0;
                n_done           = '0;
                w_released       = 1'b1;
            end
            ppd_pkg::REQ_LINE: begin
                if (r_expect_release) begin
                    // A release: back to poke mode, fully reset once all ports are done.
                    n_expect_release = 1'b0;
                    n_hold_line      = 1'b0;
                    if (&r_done) begin
                        n_current_port = ppd_pkg::PORT_NONE;
                        w_released     = 1'b1;
                    end
                end else if (32'(i_req.port) < NP) begin
                    // A poke from a neighbor: push its line back and make it active.
                    w_push         = NP'(1) << i_req.port;
                    n_current_port = ppd_pkg::CUR_W'(i_req.port);
                end
            end
            ppd_pkg::REQ_POKE: begin
                if (w_scan && (w_hit != '0)) begin
                    w_pulsed         = w_upto;
                    n_done           = r_done | w_upto;
                    w_reverse        = w_first;
                    n_expect_release = 1'b1;
                    n_current_port   = w_first_idx;
                    n_hold_line      = 1'b1;
                    w_status         = ppd_pkg::ST_OK;
                end else begin
                    // No scan or no reply: a scanning node has pulsed every undone port.
                    if (w_scan) begin
                        w_pulsed = w_undone;
                        n_done   = '1;
                    end
                    n_expect_release = 1'b0;
                    n_current_port   = ppd_pkg::PORT_NONE;
                    n_hold_line      = 1'b0;
                    w_released       = 1'b1;
                    w_status         = ppd_pkg::ST_FAIL;
                end
            end
            default: begin
            end
        endcase
    end

    // State registers, updated once per request that leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_first       <= 1'b0;
            r_expect_release <= 1'b0;
            r_current_port   <= ppd_pkg::PORT_NONE;
            r_hold_line      <= 1'b0;
            r_done           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_is_first <= i_cfg_data;
            end
            if (i_step) begin
                r_expect_release <= n_expect_release;
                r_current_port   <= n_current_port;
                r_hold_line      <= n_hold_line;
                r_done           <= n_done;
            end
        end
    end

    // The result reports the state after the step.
    always_comb begin
        o_result.status           = w_status;
        o_result.active_port      = n_current_port;
        o_result.keep_line        = n_hold_line;
        o_result.awaiting_release = n_expect_release;
        o_result.pulsed_ports     = w_pulsed;
        o_result.push_mask        = w_push;
        o_result.reverse_mask     = w_reverse;
        o_result.lines_released   = w_released;
    end

endmodule

FILE: design/ppd_out_stage.sv
// Result register of the port poke detection block: holds one result transaction
// until the downstream side takes it. Depends on ppd_pkg.
module ppd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_req,
    output logic             o_can_load,
    input  ppd_pkg::t_result i_result,
    output logic             o_valid,
    input  logic             i_stall,
    output ppd_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    ppd_pkg::t_result r_result;
    logic             w_load;

    // The register can load when empty or when its result is taken this cycle.
    assign o_can_load = !r_valid || !i_stall;
    assign w_load     = i_load_req && o_can_load;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: tb/sv/tb_port_poke_detection_fsm_top.sv
// Self-checking testbench for port_poke_detection_fsm_top: directed and random request
// transactions, a per-request predictor of the detection state and a result checker.
// Depends on ppd_pkg and port_poke_detection_fsm_top.
`timescale 1ns / 100ps

module tb_port_poke_detection_fsm_top;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 4;
    localparam int          DUT_LATENCY   = 2;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          RUN_LIMIT_NS  = 5_000_000;
    localparam int unsigned RANDOM_PHASE  = 155;

    // Clock, reset and all block inputs start at known values.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [1:0] i_req_type    = '0;
    logic [1:0] i_port        = '0;
    logic [3:0] i_reply_lines = '0;
    logic       i_stall       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic       i_cfg_data    = 1'b0;

    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_status;
    logic [2:0] o_active_port;
    logic       o_keep_line;
    logic       o_awaiting_release;
    logic [3:0] o_pulsed_ports;
    logic [3:0] o_push_mask;
    logic [3:0] o_reverse_mask;
    logic       o_lines_released;
    logic       o_cfg_ready;

    // Request transactions waiting to be sent, and results still owed by the block.
    ppd_pkg::t_req    request_backlog[$];
    ppd_pkg::t_result due_results[$];
    int unsigned      mismatches = 0;
    int unsigned      queued_count = 0;
    logic             req_taken = 1'b0;

    // Sender burst and gap bookkeeping.
    int unsigned burst_left = 0;
    int unsigned idle_left  = 0;

    // Receiver stall pattern bookkeeping.
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    int unsigned stall_tick = 0;

    // Predicted detection state and the copy of the configuration register.
    logic                          tb_first_node   = 1'b0;
    logic                          tb_wait_release = 1'b0;
    logic [ppd_pkg::CUR_W-1:0]     tb_active_port  = ppd_pkg::PORT_NONE;
    logic                          tb_hold_line    = 1'b0;
    logic [ppd_pkg::NUM_PORTS-1:0] tb_done_ports   = '0;

    port_poke_detection_fsm_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_req_type         (i_req_type),
        .i_port             (i_port),
        .i_reply_lines      (i_reply_lines),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_active_port      (o_active_port),
        .o_keep_line        (o_keep_line),
        .o_awaiting_release (o_awaiting_release),
        .o_pulsed_ports     (o_pulsed_ports),
        .o_push_mask        (o_push_mask),
        .o_reverse_mask     (o_reverse_mask),
        .o_lines_released   (o_lines_released),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // A full reset drops the held line, forgets the active port and goes back to poke mode.
    // The done marks survive it.
    function automatic void release_all_lines();
        tb_hold_line    = 1'b0;
        tb_active_port  = ppd_pkg::PORT_NONE;
        tb_wait_release = 1'b0;
    endfunction

    // Advances the predicted state by one request and returns the result it must produce.
    function automatic ppd_pkg::t_result predict_poke_step(ppd_pkg::t_req rq);
        ppd_pkg::t_result r;
        logic             found;
        int               p;
        r     = '0;
        found = 1'b0;
        case (rq.req_type)
            ppd_pkg::REQ_INIT: begin
                release_all_lines();
                tb_done_ports    = '0;
                r.lines_released = 1'b1;
            end
            ppd_pkg::REQ_LINE: begin
                if (tb_wait_release) begin
                    tb_wait_release = 1'b0;
                    tb_hold_line    = 1'b0;
                    // Once every port has been poked the round is over.
                    if (&tb_done_ports) begin
                        release_all_lines();
                        r.lines_released = 1'b1;
                    end
                end else begin
                    // The port field is two bits wide, so it is always a valid port.
                    r.push_mask    = ppd_pkg::NUM_PORTS'(1) << rq.port;
                    tb_active_port = ppd_pkg::CUR_W'(rq.port);
                end
            end
            ppd_pkg::REQ_POKE: begin
                // Only a node that was poked itself, or the master, scans its ports.
                if (tb_active_port != ppd_pkg::PORT_NONE || tb_first_node) begin
                    for (p = 0; p < ppd_pkg::NUM_PORTS; p++) begin
                        if (!found && !tb_done_ports[p]) begin
                            r.pulsed_ports[p] = 1'b1;
                            tb_done_ports[p]  = 1'b1;
                            if (rq.reply_lines[p]) begin
                                r.reverse_mask[p] = 1'b1;
                                tb_wait_release   = 1'b1;
                                tb_active_port    = ppd_pkg::CUR_W'(p);
                                tb_hold_line      = 1'b1;
                                found             = 1'b1;
                            end
                        end
                    end
                end
                if (found) begin
                    r.status = ppd_pkg::ST_OK;
                end else begin
                    release_all_lines();
                    r.lines_released = 1'b1;
                    r.status         = ppd_pkg::ST_FAIL;
                end
            end
            default: begin
            end
        endcase
        r.active_port      = tb_active_port;
        r.keep_line        = tb_hold_line;
        r.awaiting_release = tb_wait_release;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    // Monitor: records accepted requests through the predictor and checks accepted results.
    always @(posedge i_clk) begin : monitor
        ppd_pkg::t_result want;
        req_taken = i_rst_n && i_valid && !o_stall;
        if (req_taken) begin
            due_results.push_back(
                predict_poke_step(ppd_pkg::t_req'{i_req_type, i_port, i_reply_lines}));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, got status %0d port %0d",
                         $time, o_status, o_active_port);
            end else begin
                want = due_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("active_port", want.active_port, o_active_port);
                check_field("keep_line", want.keep_line, o_keep_line);
                check_field("awaiting_release", want.awaiting_release, o_awaiting_release);
                check_field("pulsed_ports", want.pulsed_ports, o_pulsed_ports);
                check_field("push_mask", want.push_mask, o_push_mask);
                check_field("reverse_mask", want.reverse_mask, o_reverse_mask);
                check_field("lines_released", want.lines_released, o_lines_released);
            end
        end
    end

    // Driver: sends the backlog in bursts of random length separated by random gaps.
    always @(negedge i_clk) begin : driver
        ppd_pkg::t_req next_req;
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (idle_left != 0) begin
                idle_left--;
                i_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
                next_req = request_backlog.pop_front();
                i_valid       <= 1'b1;
                i_req_type    <= next_req.req_type;
                i_port        <= next_req.port;
                i_reply_lines <= next_req.reply_lines;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: switches between free flow, random, heavy and periodic stalling.
    always @(negedge i_clk) begin : stall_pattern
        stall_tick++;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 60);
        end else begin
            stall_left--;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= 1'($urandom_range(0, 1));
                2:       i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (stall_tick % 3 == 0);
            endcase
        end
    end

    task automatic queue_request(ppd_pkg::t_req_type kind, logic [1:0] port_num,
                                 logic [3:0] reply);
        request_backlog.push_back(ppd_pkg::t_req'{kind, port_num, reply});
        queued_count++;
    endtask

    // Reply levels biased toward none or a single answering port.
    function automatic logic [3:0] pick_reply();
        case ($urandom_range(0, 3))
            0:       return 4'b0000;
            1:       return 4'b0001 << $urandom_range(0, 3);
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    // One discovery round: optional init, a poke from the neighbor (only at times on the
    // master), then poke-next and release pairs. Steps are dropped at random to break rounds.
    task automatic queue_discovery_round();
        int unsigned pokes;
        pokes = $urandom_range(1, 5);
        if ($urandom_range(0, 3) != 0)
            queue_request(ppd_pkg::REQ_INIT, 2'($urandom_range(0, 3)),
                          4'($urandom_range(0, 15)));
        if (!tb_first_node || $urandom_range(0, 2) == 0)
            queue_request(ppd_pkg::REQ_LINE, 2'($urandom_range(0, 3)),
                          4'($urandom_range(0, 15)));
        repeat (pokes) begin
            queue_request(ppd_pkg::REQ_POKE, 2'($urandom_range(0, 3)), pick_reply());
            if ($urandom_range(0, 4) != 0)
                queue_request(ppd_pkg::REQ_LINE, 2'($urandom_range(0, 3)),
                              4'($urandom_range(0, 15)));
        end
    endtask

    task automatic queue_random_phase(int unsigned n_items);
        int unsigned stop_at;
        stop_at = queued_count + n_items;
        while (queued_count < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                // Noise: any request kind with any field values.
                repeat ($urandom_range(1, 3))
                    queue_request(ppd_pkg::t_req_type'($urandom_range(0, 3)),
                                  2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
            end else begin
                queue_discovery_round();
            end
        end
    endtask

    // Waits for the backlog to drain and for results up to DRAIN_LIMIT, then lets the pipe settle.
    task automatic wait_until_drained();
        int unsigned waited;
        waited = 0;
        do @(posedge i_clk); while (request_backlog.size() != 0 || i_valid);
        while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DUT_LATENCY + 2) @(posedge i_clk);
    endtask

    // Writes is_first_node; only called while the block is idle.
    task automatic write_first_node(logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tb_first_node = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Ordinary node: unused request, poke without being poked, full scans and releases.
        write_first_node(1'b0);
        queue_request(ppd_pkg::REQ_UNUSED, 2'd0, 4'b0000);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b1111);
        queue_request(ppd_pkg::REQ_LINE, 2'd3, 4'b0000);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b0000);
        queue_request(ppd_pkg::REQ_LINE, 2'd1, 4'b0000);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b1111);
        queue_request(ppd_pkg::REQ_INIT, 2'd3, 4'b1111);
        queue_request(ppd_pkg::REQ_LINE, 2'd0, 4'b0000);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b1111);
        queue_request(ppd_pkg::REQ_LINE, 2'd2, 4'b0000);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b1000);
        queue_request(ppd_pkg::REQ_LINE, 2'd1, 4'b0000);
        queue_request(ppd_pkg::REQ_LINE, 2'd2, 4'b0000);
        queue_request(ppd_pkg::REQ_UNUSED, 2'd3, 4'b1111);
        queue_request(ppd_pkg::REQ_INIT, 2'd0, 4'b0000);
        wait_until_drained();

        // Master node: scans without a prior poke, including with every port already done.
        write_first_node(1'b1);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b0100);
        queue_request(ppd_pkg::REQ_LINE, 2'd3, 4'b0000);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b0000);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b1111);
        queue_request(ppd_pkg::REQ_INIT, 2'd0, 4'b0000);
        queue_request(ppd_pkg::REQ_POKE, 2'd0, 4'b0001);
        queue_request(ppd_pkg::REQ_LINE, 2'd0, 4'b0000);
        queue_request(ppd_pkg::REQ_LINE, 2'd0, 4'b0000);
        queue_random_phase(RANDOM_PHASE);
        wait_until_drained();

        write_first_node(1'b0);
        queue_random_phase(RANDOM_PHASE);
        wait_until_drained();

        write_first_node(1'b1);
        queue_random_phase(RANDOM_PHASE);
        wait_until_drained();

        write_first_node(1'b0);
        queue_random_phase(RANDOM_PHASE);
        wait_until_drained();

        if (due_results.size() != 0) begin
            mismatches += due_results.size();
            $display("%0t ns: %0d results never arrived", $time, due_results.size());
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
